// ----- sv/sms_pkg.sv -----
// Shared types and constants for the straight move supervisor.
// No dependencies; imported by sms_decide and straight_move_supervisor_core.
package sms_pkg;

  // Field widths
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned ECHO_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TARGET_W  = 15;
  localparam int unsigned SPEED_W   = 8;
  localparam int unsigned TPM_W     = 20;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned DELTA_W   = 8;
  localparam int unsigned STALL_W   = 3;
  localparam int unsigned OBST_W    = 8;
  localparam int unsigned OBST_LIM_W = 14;   // obstacle_cm * 58 fits in 14 bits
  localparam int unsigned TTICKS_W  = TARGET_W + TPM_W - 16;

  localparam int unsigned IN_DATA_W  = 104;  // 103 bits of fields, padded to bytes
  localparam int unsigned OUT_DATA_W = 48;   // 45 bits of fields, padded to bytes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Constants
  localparam logic [OBST_LIM_W-1:0] SONAR_DIV  = 14'd58;
  localparam logic [SPEED_W-1:0]    STOP_SPEED = 8'd128;
  localparam logic [STALL_W-1:0]    STALL_MAX  = 3'd7;

  // Register reset values
  localparam logic [TPM_W-1:0]      TPM_RESET      = 20'd75098;
  localparam logic [OBST_LIM_W-1:0] OBST_LIM_RESET = 14'd2030;   // 35 cm * 58
  localparam logic [TMO_W-1:0]      TMO_RESET      = 16'd10000;
  localparam logic [DELTA_W-1:0]    DELTA_RESET    = 8'd3;
  localparam logic [STALL_W-1:0]    LIMIT_RESET    = 3'd2;

  typedef enum logic [2:0] {
    ST_DRIVING  = 3'd0,
    ST_OBSTACLE = 3'd1,
    ST_REACHED  = 3'd2,
    ST_STALLED  = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_DRIVE = 2'd2,
    ACT_BACK  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_MM = 3'd0,
    CFG_OBSTACLE_CM  = 3'd1,
    CFG_TIMEOUT_MS   = 3'd2,
    CFG_STALL_DELTA  = 3'd3,
    CFG_STALL_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [TPM_W-1:0]      ticks_per_mm_q16;
    logic [OBST_LIM_W-1:0] obstacle_lim;    // echo_us below this is an obstacle
    logic [TMO_W-1:0]      timeout_ms;
    logic [DELTA_W-1:0]    stall_delta;
    logic [STALL_W-1:0]    stall_limit;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  encoder_count;
    logic [ECHO_W-1:0]   echo_us;
    logic [TIME_W-1:0]   now_ms;
    logic [TARGET_W-1:0] target_mm;
    logic [SPEED_W-1:0]  drive_speed;
  } item_t;

  typedef struct packed {
    status_t            move_status;
    action_t            motor_action;
    logic [SPEED_W-1:0] motor_speed;
    logic [COUNT_W-1:0] undo_ticks;
  } result_t;

  typedef struct packed {
    logic               timer_armed;
    logic [TIME_W-1:0]  move_start_ms;
    logic               first_tick;
    logic [STALL_W-1:0] stall_count;
    logic [COUNT_W-1:0] previous_count;
  } state_t;

endpackage

// ----- sv/sms_decide.sv -----
// Per-tick decision logic of the straight move supervisor: result and next state.
// Depends on sms_pkg.
module sms_decide (
  input  sms_pkg::cfg_t    cfg,
  input  sms_pkg::state_t  st,
  input  sms_pkg::item_t   it,
  output sms_pkg::result_t res,
  output sms_pkg::state_t  st_next
);
  import sms_pkg::*;

  logic [TIME_W-1:0]             start_ms;
  logic [TIME_W-1:0]             elapsed;
  logic [TARGET_W+TPM_W-1:0]     target_prod;
  logic [TTICKS_W-1:0]           target_ticks;
  logic [COUNT_W-1:0]            count_mag;
  logic signed [COUNT_W:0]       step;
  logic [COUNT_W:0]              step_mag;
  logic                          small_step;
  logic [STALL_W-1:0]            stall_cnt_new;

  // datapath pieces
  always_comb begin
    start_ms     = st.timer_armed ? st.move_start_ms : it.now_ms;
    elapsed      = it.now_ms - start_ms;
    target_prod  = (TARGET_W+TPM_W)'(it.target_mm) * (TARGET_W+TPM_W)'(cfg.ticks_per_mm_q16);
    target_ticks = target_prod[TARGET_W+TPM_W-1:16];
    // most negative count wraps to 2^31, which is its magnitude
    count_mag    = it.encoder_count[COUNT_W-1] ? (~it.encoder_count + 1'b1) : it.encoder_count;
    step         = $signed({it.encoder_count[COUNT_W-1], it.encoder_count})
                 - $signed({st.previous_count[COUNT_W-1], st.previous_count});
    step_mag     = step[COUNT_W] ? (~step + 1'b1) : step;
    small_step   = step_mag < (COUNT_W+1)'(cfg.stall_delta);
    if (!small_step)
      stall_cnt_new = '0;
    else if (st.stall_count == STALL_MAX)
      stall_cnt_new = STALL_MAX;
    else
      stall_cnt_new = st.stall_count + 1'b1;
  end

  // priority decision
  always_comb begin
    st_next                = st;
    st_next.previous_count = it.encoder_count;
    st_next.timer_armed    = 1'b1;
    st_next.move_start_ms  = start_ms;

    res.move_status  = ST_DRIVING;
    res.motor_action = ACT_DRIVE;
    res.motor_speed  = it.drive_speed;
    res.undo_ticks   = '0;

    if (elapsed > TIME_W'(cfg.timeout_ms)) begin
      res.move_status     = ST_TIMEOUT;
      res.motor_action    = ACT_BACK;
      res.motor_speed     = ~it.drive_speed + 1'b1;
      res.undo_ticks      = it.encoder_count;
      st_next.timer_armed = 1'b0;
    end else if (count_mag >= COUNT_W'(target_ticks)) begin
      res.move_status     = ST_REACHED;
      res.motor_action    = ACT_STOP;
      res.motor_speed     = STOP_SPEED;
      st_next.first_tick  = 1'b1;
      st_next.timer_armed = 1'b0;
    end else if (ECHO_W'(it.echo_us) < ECHO_W'(cfg.obstacle_lim)) begin
      // echo/58 < cm  <=>  echo < cm*58
      res.move_status    = ST_OBSTACLE;
      res.motor_action   = ACT_STOP;
      res.motor_speed    = STOP_SPEED;
      st_next.first_tick = 1'b1;
    end else if (!st.first_tick && (stall_cnt_new > cfg.stall_limit)) begin
      res.move_status     = ST_STALLED;
      res.motor_action    = ACT_NONE;
      res.motor_speed     = '0;
      st_next.stall_count = '0;
      st_next.first_tick  = 1'b1;
      st_next.timer_armed = 1'b0;
    end else begin
      if (!st.first_tick)
        st_next.stall_count = stall_cnt_new;
      st_next.first_tick = 1'b0;
    end
  end

endmodule

// ----- sv/straight_move_supervisor_core.sv -----
// Straight move supervisor: input register, decision logic and result register in turn;
// throughput one beat per cycle while m_tready is held high.
// The critical path is the 15x20 target multiply followed by the reached compare.
// Synchronous active-high reset: empties both stages, returns the move state to
// its idle values and the registers to their defaults.
// Depends on sms_pkg and sms_decide.
module straight_move_supervisor_core (
  input  logic                               clk,
  input  logic                               rst,
  // input beats
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [31:0] encoder_count, [47:32] echo_us, [79:48] now_ms,
  // [94:80] target_mm, [102:95] drive_speed, [103] zero
  input  logic [sms_pkg::IN_DATA_W-1:0]      s_tdata,
  // result beats
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [2:0] move_status, [4:3] motor_action, [12:5] motor_speed,
  // [44:13] undo_ticks, [47:45] zero
  output logic [sms_pkg::OUT_DATA_W-1:0]     m_tdata,
  // register writes
  input  logic                               cfg_we,
  input  logic [sms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sms_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sms_pkg::*;

  cfg_t    cfg_q;
  state_t  st_q, st_next;
  item_t   in_q;
  logic    in_valid_q;
  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    advance;

  // An item moves from the input register to the result register when the
  // result slot is empty or its beat is taken this cycle.
  assign advance  = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || advance;

  // Register file. Obstacle distance is kept pre-scaled by 58 so the
  // datapath compares echo width directly instead of dividing it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.ticks_per_mm_q16 <= TPM_RESET;
      cfg_q.obstacle_lim     <= OBST_LIM_RESET;
      cfg_q.timeout_ms       <= TMO_RESET;
      cfg_q.stall_delta      <= DELTA_RESET;
      cfg_q.stall_limit      <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_MM: cfg_q.ticks_per_mm_q16 <= cfg_data[TPM_W-1:0];
        CFG_OBSTACLE_CM:  cfg_q.obstacle_lim <= OBST_LIM_W'(cfg_data[OBST_W-1:0]) * SONAR_DIV;
        CFG_TIMEOUT_MS:   cfg_q.timeout_ms   <= cfg_data[TMO_W-1:0];
        CFG_STALL_DELTA:  cfg_q.stall_delta  <= cfg_data[DELTA_W-1:0];
        CFG_STALL_LIMIT:  cfg_q.stall_limit  <= cfg_data[STALL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: unpack the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q.encoder_count <= s_tdata[31:0];
      in_q.echo_us       <= s_tdata[47:32];
      in_q.now_ms        <= s_tdata[79:48];
      in_q.target_mm     <= s_tdata[94:80];
      in_q.drive_speed   <= s_tdata[102:95];
    end
  end

  // Decision; the move state is committed in the same cycle the item advances,
  // so the next item in line already sees it.
  sms_decide u_decide (
    .cfg     (cfg_q),
    .st      (st_q),
    .it      (in_q),
    .res     (res),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st_q.timer_armed    <= 1'b0;
      st_q.move_start_ms  <= '0;
      st_q.first_tick     <= 1'b1;
      st_q.stall_count    <= '0;
      st_q.previous_count <= '0;
    end else if (advance) begin
      st_q <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {3'b000, out_q.undo_ticks, out_q.motor_speed,
                     out_q.motor_action, out_q.move_status};

  // Checks
  a_timeout_backs_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_q.move_status == ST_TIMEOUT) |-> (out_q.motor_action == ACT_BACK))
    else $error("timeout result without back-out action");

  a_undo_only_on_timeout: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_q.move_status != ST_TIMEOUT) |-> (out_q.undo_ticks == '0))
    else $error("undo distance outside timeout");

  a_stall_clears: assert property (@(posedge clk) disable iff (rst)
    advance && (res.move_status == ST_STALLED) |=> (st_q.stall_count == '0) && st_q.first_tick)
    else $error("stall end did not clear stall state");

  a_reached_disarms: assert property (@(posedge clk) disable iff (rst)
    advance && (res.move_status == ST_REACHED) |=> !st_q.timer_armed && st_q.first_tick)
    else $error("reached did not end the move");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid_q && !m_tready |-> !advance)
    else $error("pending result overwritten");

endmodule
